FILE: rtl/gbn_pkg.sv
// ----------------------------------------------------------------------------
// gbn_pkg: shared types and constants of the go-back-n sender
// Window size, ring geometry, action codes, transfer structs and the
// command/status structs between controller and datapath.
// ----------------------------------------------------------------------------
package gbn_pkg;

	localparam int WINDOW       = 4;
	localparam int PAYLOAD_BITS = 64;
	localparam int RING_SLOTS   = 2 * WINDOW;
	localparam int SLOT_W       = $clog2(RING_SLOTS);
	localparam int CNT_W        = $clog2(WINDOW + 1);

	typedef enum logic [1:0] {
		ACT_SEND    = 2'd0,
		ACT_ACK     = 2'd1,
		ACT_TIMEOUT = 2'd2
	} action_t;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_RESEND,
		ST_DRAIN
	} state_t;

	typedef struct packed {
		logic [1:0]  action;
		logic [63:0] payload;
		logic [31:0] ack_number;
		logic        ack_checksum_ok;
		logic [31:0] expired_seq;
	} item_t;

	typedef struct packed {
		logic        accepted;
		logic        packet_valid;
		logic [31:0] packet_seq;
		logic [63:0] packet_payload;
		logic        timer_stop;
		logic [31:0] timer_stop_seq;
		logic        timer_start;
		logic [31:0] timer_start_seq;
		logic        window_full;
		logic        last;
	} result_t;

	// controller to datapath
	typedef struct packed {
		logic take;   // item accepted this cycle
		logic rd_en;  // issue one ring read for a resend
	} cmd_t;

	// datapath to controller
	typedef struct packed {
		logic resend;     // current item is a timeout with packets outstanding
		logic last_read;  // the read issued now is the final one
	} stat_t;

	function automatic logic [SLOT_W-1:0] slot_of(input logic [31:0] seq);
		return SLOT_W'(seq % RING_SLOTS);
	endfunction

endpackage

FILE: rtl/gbn_ram.sv
// ----------------------------------------------------------------------------
// gbn_ram: generic simple dual-port RAM
// One write port, one read port with registered read data.
// ----------------------------------------------------------------------------
module gbn_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 8
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

FILE: rtl/gbn_ctrl.sv
// ----------------------------------------------------------------------------
// gbn_ctrl: sender controller
// Accepts items while idle and sequences the ring reads of a resend.
// ----------------------------------------------------------------------------
module gbn_ctrl (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          start,
	input  gbn_pkg::stat_t stat,
	output gbn_pkg::cmd_t cmd,
	output logic          busy
);

	gbn_pkg::state_t state_q, state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= gbn_pkg::ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d = state_q;
		case (state_q)
			gbn_pkg::ST_IDLE: begin
				if (start && stat.resend) state_d = gbn_pkg::ST_RESEND;
			end
			gbn_pkg::ST_RESEND: begin
				if (stat.last_read) state_d = gbn_pkg::ST_DRAIN;
			end
			gbn_pkg::ST_DRAIN: begin
				state_d = gbn_pkg::ST_IDLE;
			end
			default: begin
				state_d = gbn_pkg::ST_IDLE;
			end
		endcase
	end

	always_comb begin
		busy      = 1'b1;
		cmd.take  = 1'b0;
		cmd.rd_en = 1'b0;
		case (state_q)
			gbn_pkg::ST_IDLE: begin
				busy     = 1'b0;
				cmd.take = start;
			end
			gbn_pkg::ST_RESEND: begin
				cmd.rd_en = 1'b1;
			end
			gbn_pkg::ST_DRAIN: begin
				busy = 1'b1;
			end
			default: begin
				busy = 1'b1;
			end
		endcase
	end

endmodule

FILE: rtl/gbn_dp.sv
// ----------------------------------------------------------------------------
// gbn_dp: sender datapath
// Window registers, payload ring, resend read stage and result register.
// ----------------------------------------------------------------------------
module gbn_dp (
	input  logic             clk,
	input  logic             arst_n,
	input  gbn_pkg::item_t   item,
	input  gbn_pkg::cmd_t    cmd,
	output gbn_pkg::stat_t   stat,
	output logic             strobe,
	output gbn_pkg::result_t result
);

	logic [31:0] base_q, next_q;
	logic        full_q;
	logic [gbn_pkg::CNT_W-1:0] count_q, idx_q;
	logic [31:0] expired_q;

	logic        rd_valid_s1, rd_first_s1, rd_last_s1;
	logic [31:0] rd_seq_s1;

	logic        strobe_q;
	gbn_pkg::result_t result_q;

	logic [31:0] outstanding, ack_off, new_base, rd_seq;
	logic [gbn_pkg::CNT_W-1:0] count_d;
	logic        is_send, is_ack, is_tmo, can_send, ack_good;
	logic        ram_we;
	logic [gbn_pkg::PAYLOAD_BITS-1:0] ram_rdata;
	gbn_pkg::result_t single;

	assign outstanding = next_q - base_q;
	assign ack_off     = item.ack_number - base_q;
	assign new_base    = item.ack_number + 32'd1;
	assign is_send     = item.action == gbn_pkg::ACT_SEND;
	assign is_ack      = item.action == gbn_pkg::ACT_ACK;
	assign is_tmo      = item.action == gbn_pkg::ACT_TIMEOUT;
	assign can_send    = !full_q && (outstanding < 32'(gbn_pkg::WINDOW));
	assign ack_good    = item.ack_checksum_ok && (ack_off < outstanding);
	assign count_d     = (outstanding > 32'(gbn_pkg::WINDOW)) ?
	                     gbn_pkg::CNT_W'(gbn_pkg::WINDOW) : outstanding[gbn_pkg::CNT_W-1:0];
	assign rd_seq      = base_q + 32'(idx_q);
	assign ram_we      = cmd.take && is_send && can_send;

	assign stat.resend    = is_tmo && (outstanding != 32'd0);
	assign stat.last_read = idx_q == (count_q - gbn_pkg::CNT_W'(1));

	gbn_ram #(
		.WIDTH(gbn_pkg::PAYLOAD_BITS),
		.DEPTH(gbn_pkg::RING_SLOTS)
	) u_ring (
		.clk  (clk),
		.we   (ram_we),
		.waddr(gbn_pkg::slot_of(next_q)),
		.wdata(item.payload[gbn_pkg::PAYLOAD_BITS-1:0]),
		.re   (cmd.rd_en),
		.raddr(gbn_pkg::slot_of(rd_seq)),
		.rdata(ram_rdata)
	);

	// single-result items: send, ack, timeout with nothing outstanding, unknown
	always_comb begin
		single = '0;
		single.window_full = full_q;
		single.last        = 1'b1;
		if (is_send && can_send) begin
			single.accepted       = 1'b1;
			single.packet_valid   = 1'b1;
			single.packet_seq     = next_q;
			single.packet_payload = 64'(item.payload[gbn_pkg::PAYLOAD_BITS-1:0]);
			if (outstanding == 32'd0) begin
				single.timer_start     = 1'b1;
				single.timer_start_seq = next_q;
			end
			single.window_full = (next_q + 32'd1 - base_q) == 32'(gbn_pkg::WINDOW);
		end else if (is_ack && ack_good) begin
			single.timer_stop     = 1'b1;
			single.timer_stop_seq = base_q;
			if (new_base != next_q) begin
				single.timer_start     = 1'b1;
				single.timer_start_seq = new_base;
			end
			single.window_full = 1'b0;
		end else if (is_tmo) begin
			single.timer_stop      = 1'b1;
			single.timer_stop_seq  = item.expired_seq;
			single.timer_start     = 1'b1;
			single.timer_start_seq = item.expired_seq;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			base_q      <= '0;
			next_q      <= '0;
			full_q      <= 1'b0;
			idx_q       <= '0;
			rd_valid_s1 <= 1'b0;
			strobe_q    <= 1'b0;
		end else begin
			if (cmd.take) begin
				idx_q <= '0;
				if (is_send && can_send) begin
					next_q <= next_q + 32'd1;
					full_q <= single.window_full;
				end
				if (is_ack && ack_good) begin
					base_q <= new_base;
					full_q <= 1'b0;
				end
			end else if (cmd.rd_en) begin
				idx_q <= idx_q + gbn_pkg::CNT_W'(1);
			end
			rd_valid_s1 <= cmd.rd_en;
			strobe_q    <= rd_valid_s1 || (cmd.take && !stat.resend);
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.take) begin
			count_q   <= count_d;
			expired_q <= item.expired_seq;
		end
		if (cmd.rd_en) begin
			rd_seq_s1   <= rd_seq;
			rd_first_s1 <= idx_q == '0;
			rd_last_s1  <= stat.last_read;
		end
		if (rd_valid_s1) begin
			result_q.accepted        <= 1'b0;
			result_q.packet_valid    <= 1'b1;
			result_q.packet_seq      <= rd_seq_s1;
			result_q.packet_payload  <= 64'(ram_rdata);
			result_q.timer_stop      <= rd_first_s1;
			result_q.timer_stop_seq  <= rd_first_s1 ? expired_q : 32'd0;
			result_q.timer_start     <= rd_first_s1;
			result_q.timer_start_seq <= rd_first_s1 ? expired_q : 32'd0;
			result_q.window_full     <= full_q;
			result_q.last            <= rd_last_s1;
		end else if (cmd.take) begin
			result_q <= single;
		end
	end

	assign strobe = strobe_q;
	assign result = result_q;

endmodule

FILE: rtl/go_back_n_sender.sv
// ----------------------------------------------------------------------------
// go_back_n_sender: go-back-n ARQ sender
// Numbers outgoing payloads, keeps them in a ring until acknowledged and
// resends the whole outstanding window on a timer expiry.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel: drive item and raise start; the item transfers at the
//   rising edge where start is high and busy is low.
//   Result channel: each result appears on result for exactly one cycle with
//   strobe high; the receiver takes it at the edge ending that cycle and
//   cannot hold it off. result.last marks the final result of an item.
//   A single-result item's result is registered and shows in the cycle after its item transfers.
//   Sends, acks, unknown actions and timeouts with nothing outstanding can
//   follow each other back to back; each gives one result.
//   A timeout with N packets outstanding (N up to the window size) reads the
//   payload ring once per cycle, as set by its single read port; its N results
//   arrive on consecutive cycles, through the registered ring read and the
//   result register, and busy stays high through the resend and drain states.
//   Reset: arst_n clears window base, next sequence number, full flag and the
//   controller; the payload ring is not cleared and needs no sweep.
// ----------------------------------------------------------------------------
module go_back_n_sender (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             start,
	output logic             busy,
	input  gbn_pkg::item_t   item,
	output logic             strobe,
	output gbn_pkg::result_t result
);

	gbn_pkg::cmd_t  cmd;
	gbn_pkg::stat_t stat;

	// sequence item transfers and resend reads
	gbn_ctrl u_ctrl (
		.clk   (clk),
		.arst_n(arst_n),
		.start (start),
		.stat  (stat),
		.cmd   (cmd),
		.busy  (busy)
	);

	// hold window state, ring and the result register
	gbn_dp u_dp (
		.clk   (clk),
		.arst_n(arst_n),
		.item  (item),
		.cmd   (cmd),
		.stat  (stat),
		.strobe(strobe),
		.result(result)
	);

endmodule

FILE: tb/gbn_result_checker.sv
// ----------------------------------------------------------------------------
// gbn_result_checker: result checker for the go-back-n sender
// Watches the item and result channels, predicts the packets and timer
// controls each transferred item causes, and compares every result with
// the oldest prediction, field by field.
// ----------------------------------------------------------------------------
module gbn_result_checker
	import gbn_pkg::*;
(
	input  logic    clk,
	input  logic    arst_n,
	input  logic    start,
	input  logic    busy,
	input  item_t   item,
	input  logic    strobe,
	input  result_t result,
	output int      mismatches,
	output int      awaited
);

	localparam logic [63:0] PAYLOAD_MASK = {64{1'b1}} >> (64 - PAYLOAD_BITS);

	logic [31:0] base_seq;
	logic [31:0] send_seq;
	logic        win_full;
	logic [63:0] sent_words [RING_SLOTS];
	result_t     pending_results [$];

	assign awaited = pending_results.size();

	task automatic compare_field(input string name, input logic [63:0] want,
			input logic [63:0] got);
		if (got !== want) begin
			$error("%s: expected %0h, actual %0h", name, want, got);
			mismatches++;
		end
	endtask

	task automatic compare_result(input result_t got);
		result_t want;
		want = pending_results.pop_front();
		compare_field("accepted", 64'(want.accepted), 64'(got.accepted));
		compare_field("packet_valid", 64'(want.packet_valid), 64'(got.packet_valid));
		compare_field("packet_seq", 64'(want.packet_seq), 64'(got.packet_seq));
		compare_field("packet_payload", want.packet_payload, got.packet_payload);
		compare_field("timer_stop", 64'(want.timer_stop), 64'(got.timer_stop));
		compare_field("timer_stop_seq", 64'(want.timer_stop_seq),
			64'(got.timer_stop_seq));
		compare_field("timer_start", 64'(want.timer_start), 64'(got.timer_start));
		compare_field("timer_start_seq", 64'(want.timer_start_seq),
			64'(got.timer_start_seq));
		compare_field("window_full", 64'(want.window_full), 64'(got.window_full));
		compare_field("last", 64'(want.last), 64'(got.last));
	endtask

	// Work out the results of one transferred item and advance the window.
	task automatic sender_outcome(input item_t it);
		result_t     r;
		logic [31:0] in_flight;
		logic [31:0] seq;
		int          resends;
		int          n;
		in_flight = send_seq - base_seq;
		r = '0;
		case (it.action)
			ACT_SEND: begin
				if (!win_full && in_flight < WINDOW) begin
					sent_words[slot_of(send_seq)] = it.payload & PAYLOAD_MASK;
					r.accepted       = 1'b1;
					r.packet_valid   = 1'b1;
					r.packet_seq     = send_seq;
					r.packet_payload = it.payload & PAYLOAD_MASK;
					if (in_flight == 0) begin
						r.timer_start     = 1'b1;
						r.timer_start_seq = send_seq;
					end
					send_seq = send_seq + 1;
					win_full = (send_seq - base_seq) == WINDOW;
				end
				r.window_full = win_full;
				r.last        = 1'b1;
				pending_results.push_back(r);
			end
			ACT_ACK: begin
				if (it.ack_checksum_ok && (it.ack_number - base_seq) < in_flight) begin
					r.timer_stop     = 1'b1;
					r.timer_stop_seq = base_seq;
					if (it.ack_number + 32'd1 != send_seq) begin
						r.timer_start     = 1'b1;
						r.timer_start_seq = it.ack_number + 32'd1;
					end
					base_seq = it.ack_number + 32'd1;
					win_full = 1'b0;
				end
				r.window_full = win_full;
				r.last        = 1'b1;
				pending_results.push_back(r);
			end
			ACT_TIMEOUT: begin
				resends = (in_flight > WINDOW) ? WINDOW : int'(in_flight);
				n = (resends > 0) ? resends : 1;
				for (int k = 0; k < n; k++) begin
					r = '0;
					if (k == 0) begin
						r.timer_stop      = 1'b1;
						r.timer_stop_seq  = it.expired_seq;
						r.timer_start     = 1'b1;
						r.timer_start_seq = it.expired_seq;
					end
					if (k < resends) begin
						seq = base_seq + k;
						r.packet_valid   = 1'b1;
						r.packet_seq     = seq;
						r.packet_payload = sent_words[slot_of(seq)];
					end
					r.window_full = win_full;
					r.last        = (k == n - 1);
					pending_results.push_back(r);
				end
			end
			default: begin
				r.window_full = win_full;
				r.last        = 1'b1;
				pending_results.push_back(r);
			end
		endcase
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			base_seq = '0;
			send_seq = '0;
			win_full = 1'b0;
			pending_results.delete();
		end else begin
			// Compare first: a result seen now belongs to an older item.
			if (strobe) begin
				if (pending_results.size() == 0) begin
					$error("result with no prediction waiting: %p", result);
					mismatches++;
				end else begin
					compare_result(result);
				end
			end
			if (start && !busy)
				sender_outcome(item);
		end
	end

	initial mismatches = 0;

endmodule

FILE: tb/tb_go_back_n_sender.sv
// ----------------------------------------------------------------------------
// tb_go_back_n_sender: testbench for the go-back-n sender
// Drives a directed opening (empty window, full window, refused sends,
// broken and stale acks, timeouts with and without packets in flight, the
// upper ring slots) and then random traffic in bursts, mostly well-formed acks
// steered into the window. A separate checker predicts and compares every
// result; this module makes stimulus, runs the watchdog and gives the verdict.
// ----------------------------------------------------------------------------
module tb_go_back_n_sender;

	import gbn_pkg::*;

	// Action code the block must ignore.
	localparam logic [1:0] ACT_UNDEFINED = 2'd3;
	localparam int RANDOM_ITEMS = 310;
	localparam int STALL_LIMIT  = 1000;

	logic    clk = 1'b0;
	logic    arst_n = 1'b0;
	logic    start = 1'b0;
	logic    busy;
	item_t   item = '0;
	logic    strobe;
	result_t result;
	int      mismatches;
	int      awaited;
	int      idle_cycles = 0;

	// Shadow of the window, kept only to steer acks into range.
	logic [31:0] win_head = '0;
	logic [31:0] win_tail = '0;
	int          burst_left = 0;

	go_back_n_sender uut (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.busy   (busy),
		.item   (item),
		.strobe (strobe),
		.result (result)
	);

	gbn_result_checker checker_i (
		.clk        (clk),
		.arst_n     (arst_n),
		.start      (start),
		.busy       (busy),
		.item       (item),
		.strobe     (strobe),
		.result     (result),
		.mismatches (mismatches),
		.awaited    (awaited)
	);

	initial begin
		forever #5 clk = ~clk;
	end

	// Watchdog: end the run if neither channel moves for too long.
	always @(posedge clk) begin
		if (arst_n) begin
			if ((start && !busy) || strobe) begin
				idle_cycles <= 0;
			end else if (idle_cycles >= STALL_LIMIT) begin
				$display("go_back_n_sender test failed");
				$finish;
			end else begin
				idle_cycles <= idle_cycles + 1;
			end
		end
	end

	function automatic logic [63:0] rand64();
		return {$urandom, $urandom};
	endfunction

	// Present one item, hold it until it transfers, then pace the sender:
	// keep start high inside a burst, drop it for a random gap between bursts.
	task automatic transfer_item(input logic [1:0] act, input logic [63:0] word,
			input logic [31:0] ack_no, input logic ack_ok, input logic [31:0] tag);
		item_t it;
		int    gap;
		it.action          = act;
		it.payload         = word;
		it.ack_number      = ack_no;
		it.ack_checksum_ok = ack_ok;
		it.expired_seq     = tag;
		// Track the window so later acks can be aimed inside it.
		if (act == ACT_SEND && (win_tail - win_head) < WINDOW)
			win_tail = win_tail + 1;
		else if (act == ACT_ACK && ack_ok && (ack_no - win_head) < (win_tail - win_head))
			win_head = ack_no + 1;
		start <= 1'b1;
		item  <= it;
		// Busy sampled here is the value the block saw at this edge.
		do @(posedge clk); while (busy);
		if (burst_left > 0) begin
			burst_left--;
		end else begin
			gap = $urandom_range(0, 8);
			if (gap > 0) begin
				start <= 1'b0;
				// Drive junk while idle; the block must not take it.
				repeat (gap) begin
					item <= {2'($urandom), rand64(), $urandom, 1'($urandom), $urandom};
					@(posedge clk);
				end
			end
			burst_left = $urandom_range(0, 12);
		end
	endtask

	task automatic send_word(input logic [63:0] word);
		transfer_item(ACT_SEND, word, $urandom, 1'($urandom), $urandom);
	endtask

	task automatic ack_upto(input logic [31:0] ack_no, input logic ack_ok);
		transfer_item(ACT_ACK, rand64(), ack_no, ack_ok, $urandom);
	endtask

	task automatic expire(input logic [31:0] tag);
		transfer_item(ACT_TIMEOUT, rand64(), $urandom, 1'($urandom), tag);
	endtask

	// One random item: mostly sends and in-window acks, some timeouts,
	// and a share of noise (stale or broken acks, the unused action).
	task automatic random_item();
		int          pick;
		logic [31:0] in_flight;
		in_flight = win_tail - win_head;
		pick = $urandom_range(0, 99);
		if (pick < 48) begin
			send_word(rand64());
		end else if (pick < 78) begin
			if (in_flight > 0 && $urandom_range(0, 99) < 80) begin
				ack_upto(win_head + $urandom_range(0, in_flight - 1), 1'b1);
			end else begin
				case ($urandom_range(0, 3))
					0: ack_upto($urandom, 1'($urandom));
					1: ack_upto(win_head + $urandom_range(0, WINDOW), 1'b0);
					2: ack_upto(win_head - 1, 1'b1);
					default: ack_upto(win_tail, 1'b1);
				endcase
			end
		end else if (pick < 95) begin
			expire($urandom);
		end else begin
			transfer_item(ACT_UNDEFINED, rand64(), $urandom, 1'($urandom), $urandom);
		end
	endtask

	initial begin
		// Hold reset, then release it at an edge.
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Empty window: ack with nothing in flight, bare timeout, unused action.
		ack_upto(32'd0, 1'b1);
		expire(32'hFFFF_FFFF);
		transfer_item(ACT_UNDEFINED, '1, '1, 1'b1, '1);
		// Fill the window with extreme payloads, then send while full.
		send_word(64'd0);
		send_word('1);
		send_word(64'hA5A5_5A5A_0F0F_F0F0);
		send_word(64'h8000_0000_0000_0001);
		send_word(64'h1234_5678_9ABC_DEF0);
		// Timeout with a full window: four resends, controls on the first only.
		expire(32'd0);
		// Broken and out-of-window acks change nothing.
		ack_upto(32'd1, 1'b0);
		ack_upto(32'hFFFF_FFFF, 1'b1);
		ack_upto(32'd4, 1'b1);
		// Partial ack restarts the timer; timeout resends what is left.
		ack_upto(32'd1, 1'b1);
		expire(32'h7FFF_FFFF);
		// Ack everything: timer stops with no restart.
		ack_upto(32'd3, 1'b1);
		// Fill the upper ring slots, refuse one more, then resend and clear.
		repeat (5) send_word(rand64());
		expire(32'h8000_0000);
		ack_upto(win_tail - 1, 1'b1);
		expire(32'd1);

		repeat (RANDOM_ITEMS) random_item();

		// Drain: nothing more to send, wait for every predicted result.
		start <= 1'b0;
		@(posedge clk);
		while (awaited != 0) @(posedge clk);
		repeat (2 * WINDOW + 4) @(posedge clk);
		if (mismatches == 0 && awaited == 0)
			$display("go_back_n_sender test passed");
		else
			$display("go_back_n_sender test failed");
		$finish;
	end

endmodule

FILE: go_back_n_sender.f
rtl/gbn_pkg.sv
rtl/gbn_ram.sv
rtl/gbn_ctrl.sv
rtl/gbn_dp.sv
rtl/go_back_n_sender.sv
tb/gbn_result_checker.sv
tb/tb_go_back_n_sender.sv
